// ===== rtl/tile_viewport_camera_macros.svh =====
// Assertion macros shared by the viewport camera RTL.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef TILE_VIEWPORT_CAMERA_MACROS_SVH
`define TILE_VIEWPORT_CAMERA_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TVC_ASSERT_IMP(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TVC_ASSERT_NXT(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

// Invariant checked at every clock edge outside reset.
`define TVC_ASSERT_ALW(name, clock, reset, cond, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (cond)) \
    else $error(msg);

`endif

// ===== rtl/tvc_pkg.sv =====
// Shared types and constants of the tile viewport camera.
// Used by the register file, the divider and the top level; no dependencies.
`default_nettype none

package tvc_pkg;

  // Field widths
  localparam int POS_W     = 16;
  localparam int ZOOM_W    = 4;
  localparam int SPEED_W   = 10;
  localparam int VIEW_W    = 12;
  localparam int MAP_W     = 11;
  localparam int ACT_W     = 3;
  localparam int FT_W      = 20;

  // Configuration port
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  // Quotient bits retired per divider cycle
  localparam int DIV_STEP  = 4;

  // Command codes
  typedef enum logic [ACT_W-1:0] {
    ACT_UP       = 3'd0,
    ACT_DOWN     = 3'd1,
    ACT_LEFT     = 3'd2,
    ACT_RIGHT    = 3'd3,
    ACT_ZOOM_IN  = 3'd4,
    ACT_ZOOM_OUT = 3'd5,
    ACT_CLIP     = 3'd6
  } tvc_action_t;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PAN_SPEED   = 3'd0,
    REG_PAN_LIMIT_X = 3'd1,
    REG_PAN_LIMIT_Y = 3'd2,
    REG_VIEW_WIDTH  = 3'd3,
    REG_VIEW_HEIGHT = 3'd4,
    REG_MAP_COLS    = 3'd5,
    REG_MAP_ROWS    = 3'd6
  } tvc_reg_t;

  // Register reset values
  localparam logic [SPEED_W-1:0] RST_PAN_SPEED   = 10'd8;
  localparam logic [POS_W-1:0]   RST_PAN_LIMIT_X = 16'd0;
  localparam logic [POS_W-1:0]   RST_PAN_LIMIT_Y = 16'd0;
  localparam logic [VIEW_W-1:0]  RST_VIEW_WIDTH  = 12'd640;
  localparam logic [VIEW_W-1:0]  RST_VIEW_HEIGHT = 12'd480;
  localparam logic [MAP_W-1:0]   RST_MAP_COLS    = 11'd64;
  localparam logic [MAP_W-1:0]   RST_MAP_ROWS    = 11'd64;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [SPEED_W-1:0] pan_speed;
    logic [POS_W-1:0]   pan_limit_x;
    logic [POS_W-1:0]   pan_limit_y;
    logic [VIEW_W-1:0]  view_width;
    logic [VIEW_W-1:0]  view_height;
    logic [MAP_W-1:0]   map_cols;
    logic [MAP_W-1:0]   map_rows;
  } tvc_cfg_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } tvc_div_stat_t;

  // Command sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PAN,
    ST_SZ_GO,
    ST_SZ_WAIT,
    ST_NZ_GO,
    ST_NZ_WAIT,
    ST_ZMID,
    ST_ZDIV_GO,
    ST_ZDIV_WAIT,
    ST_ZBND,
    ST_ZCLAMP,
    ST_CW_GO,
    ST_CW_WAIT,
    ST_CT_GO,
    ST_CT_WAIT,
    ST_CIDX,
    ST_CSUM,
    ST_OUT
  } tvc_state_t;

endpackage

`default_nettype wire

// ===== rtl/tvc_regs.sv =====
// APB-style configuration register file of the viewport camera.
// Depends on tvc_pkg for the register map, reset values and config struct.
`default_nettype none

module tvc_regs
  import tvc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output tvc_cfg_t               cfg
);

  tvc_reg_t reg_idx;
  logic     wr_en;

  // Never insert wait states
  assign pready  = 1'b1;
  assign reg_idx = tvc_reg_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Update the addressed register on a write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pan_speed   <= RST_PAN_SPEED;
      cfg.pan_limit_x <= RST_PAN_LIMIT_X;
      cfg.pan_limit_y <= RST_PAN_LIMIT_Y;
      cfg.view_width  <= RST_VIEW_WIDTH;
      cfg.view_height <= RST_VIEW_HEIGHT;
      cfg.map_cols    <= RST_MAP_COLS;
      cfg.map_rows    <= RST_MAP_ROWS;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PAN_SPEED:   cfg.pan_speed   <= pwdata[SPEED_W-1:0];
        REG_PAN_LIMIT_X: cfg.pan_limit_x <= pwdata[POS_W-1:0];
        REG_PAN_LIMIT_Y: cfg.pan_limit_y <= pwdata[POS_W-1:0];
        REG_VIEW_WIDTH:  cfg.view_width  <= pwdata[VIEW_W-1:0];
        REG_VIEW_HEIGHT: cfg.view_height <= pwdata[VIEW_W-1:0];
        REG_MAP_COLS:    cfg.map_cols    <= pwdata[MAP_W-1:0];
        REG_MAP_ROWS:    cfg.map_rows    <= pwdata[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero beyond the map
  always_comb begin
    case (reg_idx)
      REG_PAN_SPEED:   prdata = DATA_W'(cfg.pan_speed);
      REG_PAN_LIMIT_X: prdata = DATA_W'(cfg.pan_limit_x);
      REG_PAN_LIMIT_Y: prdata = DATA_W'(cfg.pan_limit_y);
      REG_VIEW_WIDTH:  prdata = DATA_W'(cfg.view_width);
      REG_VIEW_HEIGHT: prdata = DATA_W'(cfg.view_height);
      REG_MAP_COLS:    prdata = DATA_W'(cfg.map_cols);
      REG_MAP_ROWS:    prdata = DATA_W'(cfg.map_rows);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/tvc_div.sv =====
// Shared iterative unsigned divider, DIV_STEP quotient bits per cycle.
// Depends on tvc_pkg for the step size and status struct, and on the macro header.
`default_nettype none
`include "tile_viewport_camera_macros.svh"

module tvc_div
  import tvc_pkg::*;
#(
  parameter int DVD_W = 23,
  parameter int DVS_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic      [DVD_W-1:0] quotient,
  output tvc_div_stat_t         stat
);

  localparam int NCYC  = (DVD_W + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD_W = NCYC * DIV_STEP;
  localparam int CNT_W = $clog2(NCYC + 1);

  logic [PAD_W-1:0] acc;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [PAD_W-1:0] step_acc;
  logic [DVS_W-1:0] step_rem;

  // Retire DIV_STEP restoring steps: dividend bits shift out the top,
  // quotient bits shift in at the bottom
  always_comb begin
    logic [DVS_W:0] trial;
    step_acc = acc;
    step_rem = rem;
    trial    = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial    = {step_rem, step_acc[PAD_W-1]};
      step_acc = {step_acc[PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial       = trial - {1'b0, dvs};
        step_acc[0] = 1'b1;
      end
      step_rem = trial[DVS_W-1:0];
    end
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NCYC);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Load operands, then advance the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= PAD_W'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      acc <= step_acc;
      rem <= step_rem;
    end
  end

  assign quotient  = acc[DVD_W-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

  `TVC_ASSERT_IMP(a_start_idle, clk, rst, start, !busy, "divider started while busy")
  `TVC_ASSERT_IMP(a_dvs_nonzero, clk, rst, start, divisor != '0, "divide by zero issued")
  `TVC_ASSERT_NXT(a_done_last, clk, rst, busy && cnt == CNT_W'(1), done && !busy, "divider did not finish")

endmodule

`default_nettype wire

// ===== rtl/tile_viewport_camera.sv =====
// Tile map viewport camera: top level with command sequencer and datapath; uses tvc_pkg,
// tvc_regs, tvc_div and the macro header. One command is taken when in_ready is high and
// answered by one result transaction. Zoom and clip commands make passes through the shared
// divider, which retires four quotient bits a cycle. A result is held back from the output
// register only while a previous result still waits in it. The sequencer works on one
// command at a time, and configuration is to be written only while it is idle; the block
// itself does not enforce this.
`default_nettype none
`include "tile_viewport_camera_macros.svh"

module tile_viewport_camera
  import tvc_pkg::*;
#(
  parameter int TILE_PIX = 32,
  parameter int ZOOM_LO  = 1,
  parameter int ZOOM_HI  = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // command channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ACT_W-1:0]  action,
  input  wire logic [MAP_W-1:0]  clip_map_cols,
  input  wire logic [MAP_W-1:0]  clip_map_rows,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [POS_W-1:0]       pos_x,
  output logic [POS_W-1:0]       pos_y,
  output logic [ZOOM_W-1:0]      zoom_level,
  output logic [MAP_W-1:0]       visible_cols,
  output logic [MAP_W-1:0]       visible_rows,
  output logic [FT_W-1:0]        first_tile_index,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int SZ_W   = $clog2(TILE_PIX + 1);
  localparam int MB_W   = (SZ_W > MAP_W) ? SZ_W : MAP_W;
  localparam int MID_W  = POS_W + 1;
  localparam int DVD_W  = MID_W + SZ_W;
  localparam int DVS_W  = (SZ_W > ZOOM_W) ? SZ_W : ZOOM_W;
  localparam int PROD_W = MID_W + MB_W;
  localparam int NX_W   = DVD_W + 1;
  localparam int BND_W  = PROD_W + 1;
  localparam int ZW_S   = ZOOM_W + 2;
  localparam int PV_W   = POS_W + 2;

  localparam logic [ZOOM_W-1:0]      ZMIN   = ZOOM_W'(ZOOM_LO);
  localparam logic [ZOOM_W-1:0]      ZMAX   = ZOOM_W'(ZOOM_HI);
  localparam logic signed [ZW_S-1:0] ZMIN_S = ZW_S'(ZOOM_LO);
  localparam logic signed [ZW_S-1:0] ZMAX_S = ZW_S'(ZOOM_HI);
  localparam logic [DVD_W-1:0]       TILE_D = DVD_W'(TILE_PIX);
  localparam logic [POS_W-1:0]       POS_MAX = '1;

  tvc_cfg_t      cfg;
  tvc_state_t    state;
  tvc_state_t    state_next;
  tvc_div_stat_t div_stat;

  // command and architectural state
  tvc_action_t       act;
  logic [MAP_W-1:0]  mc;
  logic [MAP_W-1:0]  mr;
  logic [POS_W-1:0]  cam_x;
  logic [POS_W-1:0]  cam_y;
  logic [ZOOM_W-1:0] cur_zoom;
  logic              axis;

  // working registers
  logic [SZ_W-1:0]          size_old;
  logic [SZ_W-1:0]          size_new;
  logic [PROD_W-1:0]        prod;
  logic signed [NX_W-1:0]   znx;
  logic [MAP_W-1:0]         vis_c;
  logic [MAP_W-1:0]         vis_r;
  logic [MAP_W-1:0]         tile_x;
  logic [MAP_W-1:0]         tile_y;
  logic [FT_W-1:0]          first;

  // combinational datapath
  logic                     in_accept;
  logic                     out_load;
  logic                     div_start;
  logic [DVD_W-1:0]         div_dvd;
  logic [DVS_W-1:0]         div_dvs;
  logic [DVD_W-1:0]         div_q;
  logic [SZ_W-1:0]          size_q;
  logic [POS_W-1:0]         cam_ax;
  logic [VIEW_W-1:0]        w_ax;
  logic [VIEW_W-1:0]        w_half;
  logic [MAP_W-1:0]         map_ax;
  logic [MAP_W-1:0]         m_ax;
  logic [MAP_W-1:0]         vis_ax;
  logic [MAP_W-1:0]         t_lim;
  logic [MAP_W-1:0]         vis_val;
  logic [MAP_W-1:0]         t_val;
  logic [MID_W-1:0]         mid;
  logic [MID_W-1:0]         mul_a;
  logic [MB_W-1:0]          mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic [PROD_W-1:0]        idx_sum;
  logic signed [ZW_S-1:0]   want;
  logic [ZOOM_W-1:0]        zoom_want;
  logic signed [BND_W-1:0]  nx_e;
  logic signed [BND_W-1:0]  bound;
  logic signed [BND_W-1:0]  zc;
  logic [POS_W-1:0]         zoom_new;
  logic                     pan_y;
  logic                     pan_sub;
  logic [POS_W-1:0]         pan_cam;
  logic [POS_W-1:0]         pan_lim;
  logic signed [PV_W-1:0]   pan_v;
  logic [POS_W-1:0]         pan_new;
  logic                     zoom_ok;
  logic                     y_quiet;

  // Saturate a signed value into the position range
  function automatic logic [POS_W-1:0] sat_pos(input logic signed [BND_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(BND_W'(POS_MAX))) begin
      r = POS_MAX;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  tvc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tvc_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // Select the axis under work
  assign cam_ax = axis ? cam_y : cam_x;
  assign w_ax   = axis ? cfg.view_height : cfg.view_width;
  assign map_ax = axis ? cfg.map_rows : cfg.map_cols;
  assign m_ax   = axis ? mr : mc;
  assign vis_ax = axis ? vis_r : vis_c;
  assign w_half = w_ax >> 1;
  assign mid    = {1'b0, cam_ax} + MID_W'(w_half);

  // Tile size from a quotient, never below one
  assign size_q = (div_q == '0) ? SZ_W'(1) : div_q[SZ_W-1:0];

  // Step the zoom and clamp it, lower bound first
  always_comb begin
    if (act == ACT_ZOOM_IN) begin
      want = $signed({2'b00, cur_zoom}) - ZW_S'(1);
    end else begin
      want = $signed({2'b00, cur_zoom}) + ZW_S'(1);
    end
    if (want < ZMIN_S) begin
      zoom_want = ZMIN;
    end else if (want > ZMAX_S) begin
      zoom_want = ZMAX;
    end else begin
      zoom_want = want[ZOOM_W-1:0];
    end
  end

  // Pan one axis by the configured speed and clamp to its limit
  always_comb begin
    pan_y   = (act == ACT_UP) || (act == ACT_DOWN);
    pan_sub = (act == ACT_UP) || (act == ACT_LEFT);
    pan_cam = pan_y ? cam_y : cam_x;
    pan_lim = pan_y ? cfg.pan_limit_y : cfg.pan_limit_x;
    if (pan_sub) begin
      pan_v = $signed({2'b00, pan_cam}) - $signed(PV_W'(cfg.pan_speed));
    end else begin
      pan_v = $signed({2'b00, pan_cam}) + $signed(PV_W'(cfg.pan_speed));
    end
    if (pan_v < 0) begin
      pan_new = '0;
    end else if (pan_v > $signed({2'b00, pan_lim})) begin
      pan_new = pan_lim;
    end else begin
      pan_new = pan_v[POS_W-1:0];
    end
  end

  // Clamp the rescaled position to the scaled map, then saturate
  always_comb begin
    nx_e  = BND_W'(znx);
    bound = $signed({1'b0, prod}) - $signed(BND_W'(w_ax));
    if (znx < 0) begin
      zc = '0;
    end else if (nx_e > bound) begin
      zc = bound;
    end else begin
      zc = nx_e;
    end
    zoom_new = sat_pos(zc);
  end

  // Clip window: visible count and first tile clamp
  assign vis_val = (div_q > DVD_W'(m_ax)) ? m_ax : div_q[MAP_W-1:0];
  assign t_lim   = m_ax - vis_ax;
  assign t_val   = (div_q > DVD_W'(t_lim)) ? t_lim : div_q[MAP_W-1:0];
  assign idx_sum = PROD_W'(tile_x) + prod;

  // Shared multiplier operands
  always_comb begin
    case (state)
      ST_ZMID: begin
        mul_a = mid;
        mul_b = MB_W'(size_new);
      end
      ST_ZBND: begin
        mul_a = MID_W'(map_ax);
        mul_b = MB_W'(size_new);
      end
      ST_CIDX: begin
        mul_a = MID_W'(tile_y);
        mul_b = MB_W'(mc);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Shared divider operands
  always_comb begin
    case (state)
      ST_SZ_GO: begin
        div_dvd = TILE_D;
        div_dvs = DVS_W'(cur_zoom);
      end
      ST_NZ_GO: begin
        div_dvd = TILE_D;
        div_dvs = DVS_W'(zoom_want);
      end
      ST_ZDIV_GO: begin
        div_dvd = prod[DVD_W-1:0];
        div_dvs = DVS_W'(size_old);
      end
      ST_CW_GO: begin
        div_dvd = DVD_W'(w_ax) + DVD_W'(size_old) - DVD_W'(1);
        div_dvs = DVS_W'(size_old);
      end
      ST_CT_GO: begin
        div_dvd = DVD_W'(cam_ax);
        div_dvs = DVS_W'(size_old);
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action inside {ACT_UP, ACT_DOWN, ACT_LEFT, ACT_RIGHT}) begin
            state_next = ST_PAN;
          end else if (action inside {ACT_ZOOM_IN, ACT_ZOOM_OUT, ACT_CLIP}) begin
            state_next = ST_SZ_GO;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_PAN:   state_next = ST_OUT;
      ST_SZ_GO: begin
        div_start  = 1'b1;
        state_next = ST_SZ_WAIT;
      end
      ST_SZ_WAIT: begin
        if (div_stat.done) begin
          state_next = (act == ACT_CLIP) ? ST_CW_GO : ST_NZ_GO;
        end
      end
      ST_NZ_GO: begin
        div_start  = 1'b1;
        state_next = ST_NZ_WAIT;
      end
      ST_NZ_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_ZMID;
        end
      end
      ST_ZMID:  state_next = ST_ZDIV_GO;
      ST_ZDIV_GO: begin
        div_start  = 1'b1;
        state_next = ST_ZDIV_WAIT;
      end
      ST_ZDIV_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_ZBND;
        end
      end
      ST_ZBND:   state_next = ST_ZCLAMP;
      ST_ZCLAMP: state_next = axis ? ST_OUT : ST_ZMID;
      ST_CW_GO: begin
        div_start  = 1'b1;
        state_next = ST_CW_WAIT;
      end
      ST_CW_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_CT_GO;
        end
      end
      ST_CT_GO: begin
        div_start  = 1'b1;
        state_next = ST_CT_WAIT;
      end
      ST_CT_WAIT: begin
        if (div_stat.done) begin
          state_next = axis ? ST_CIDX : ST_CW_GO;
        end
      end
      ST_CIDX: state_next = ST_CSUM;
      ST_CSUM: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_accept = in_valid && in_ready;

  // Update camera state, axis select and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x     <= '0;
      cam_y     <= '0;
      cur_zoom  <= ZMIN;
      axis      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // raise valid on a new result, drop it once the transaction completes
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_accept) begin
        axis <= 1'b0;
      end
      case (state)
        ST_PAN: begin
          if (pan_y) begin
            cam_y <= pan_new;
          end else begin
            cam_x <= pan_new;
          end
        end
        ST_NZ_GO: cur_zoom <= zoom_want;
        ST_ZCLAMP: begin
          if (axis) begin
            cam_y <= zoom_new;
          end else begin
            cam_x <= zoom_new;
          end
          axis <= ~axis;
        end
        ST_CT_WAIT: begin
          if (div_stat.done) begin
            axis <= ~axis;
          end
        end
        default: ;
      endcase
    end
  end

  // Capture the command and the intermediate results
  always_ff @(posedge clk) begin
    if (in_accept) begin
      act   <= tvc_action_t'(action);
      mc    <= clip_map_cols;
      mr    <= clip_map_rows;
      vis_c <= '0;
      vis_r <= '0;
      first <= '0;
    end
    case (state)
      ST_SZ_WAIT: begin
        if (div_stat.done) begin
          size_old <= size_q;
        end
      end
      ST_NZ_WAIT: begin
        if (div_stat.done) begin
          size_new <= size_q;
        end
      end
      ST_ZMID, ST_ZBND, ST_CIDX: prod <= mul_p;
      ST_ZDIV_WAIT: begin
        if (div_stat.done) begin
          znx <= $signed({1'b0, div_q}) - $signed(NX_W'(w_half));
        end
      end
      ST_CW_WAIT: begin
        if (div_stat.done) begin
          if (axis) begin
            vis_r <= vis_val;
          end else begin
            vis_c <= vis_val;
          end
        end
      end
      ST_CT_WAIT: begin
        if (div_stat.done) begin
          if (axis) begin
            tile_y <= t_val;
          end else begin
            tile_x <= t_val;
          end
        end
      end
      ST_CSUM: first <= idx_sum[FT_W-1:0];
      default: ;
    endcase
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x            <= cam_x;
      pos_y            <= cam_y;
      zoom_level       <= cur_zoom;
      visible_cols     <= vis_c;
      visible_rows     <= vis_r;
      first_tile_index <= first;
    end
  end

  // Conditions watched by the checks below
  assign zoom_ok = (cur_zoom >= ZMIN && cur_zoom <= ZMAX) || cur_zoom == ZMIN
                   || cur_zoom == ZMAX;
  assign y_quiet = state != ST_PAN && state != ST_ZCLAMP;

  `TVC_ASSERT_ALW(a_zoom_range, clk, rst, zoom_ok, "zoom outside its clamp range")
  `TVC_ASSERT_IMP(a_idle_div, clk, rst, state == ST_IDLE, !div_stat.busy, "divider busy while idle")
  `TVC_ASSERT_NXT(a_y_hold, clk, rst, y_quiet, $stable(cam_y), "cam_y moved outside pan or zoom")

endmodule

`default_nettype wire
